@@ hw/rtl/counter_bank_lazy_raise_to_max_unit_assert.svh @@
// -----------------------------------------------------------------------------
// Counter bank assertion macros
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// -----------------------------------------------------------------------------
`ifndef COUNTER_BANK_LAZY_RAISE_TO_MAX_UNIT_ASSERT_SVH
`define COUNTER_BANK_LAZY_RAISE_TO_MAX_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define CBL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define CBL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CBL_ASSERT_IMP(label, clk, rst, ante, cons)
`define CBL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ hw/rtl/cbl_pkg.sv @@
// -----------------------------------------------------------------------------
// Counter bank package
// Shared constants, types and helpers of the lazy-floor counter bank.
// -----------------------------------------------------------------------------
package cbl_pkg;

   localparam int COUNTER_DEPTH = 1024;
   localparam int COUNT_BITS    = 32;
   localparam int ADDR_W        = (COUNTER_DEPTH > 1) ? $clog2(COUNTER_DEPTH) : 1;

   localparam int FUNC_W   = 2;
   localparam int INDEX_W  = 10;
   localparam int VALUE_W  = 32;
   localparam int ACTIVE_W = 11;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 11'd1024;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ACTIVE_ADDR = 2'd0;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INC   = 2'd0,
      FUNC_RAISE = 2'd1,
      FUNC_READ  = 2'd2
   } cbl_func_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } cbl_state_type;

   function automatic logic index_ok(input logic [INDEX_W-1:0] idx,
                                     input logic [ACTIVE_W-1:0] active);
      logic below_active;
      logic below_depth;
      below_active = ({{(ACTIVE_W-INDEX_W){1'b0}}, idx} < active);
      below_depth  = (32'(idx) < 32'(COUNTER_DEPTH));
      return below_active && below_depth;
   endfunction

endpackage

@@ hw/rtl/cbl_ram.sv @@
// -----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, registered read data.
// -----------------------------------------------------------------------------
module cbl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/cbl_csr.sv @@
// -----------------------------------------------------------------------------
// Counter bank register port
// APB-style access to the active counter count.
// -----------------------------------------------------------------------------
module cbl_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [cbl_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [cbl_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [cbl_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready,
   output logic [cbl_pkg::ACTIVE_W-1:0]        active_counters
);

   logic [cbl_pkg::ACTIVE_W-1:0] active_ff;
   logic [cbl_pkg::ACTIVE_W-1:0] active_in;
   logic                         hit;

   assign pready = 1'b1;
   assign hit    = (paddr == cbl_pkg::CSR_ACTIVE_ADDR);

   always_comb begin
      active_in = active_ff;
      if (psel && penable && pwrite && hit) begin
         active_in = pwdata[cbl_pkg::ACTIVE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= cbl_pkg::ACTIVE_RESET;
      end else begin
         active_ff <= active_in;
      end
   end

   assign prdata = hit ? {{(cbl_pkg::CSR_DATA_W-cbl_pkg::ACTIVE_W){1'b0}}, active_ff}
                       : '0;
   assign active_counters = active_ff;

endmodule

@@ hw/rtl/counter_bank_lazy_raise_to_max_unit.sv @@
// -----------------------------------------------------------------------------
// Counter bank with running maximum and lazy floor
// Increment, raise-all and read over a RAM of counters.
// -----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall) carries func and counter_index.
//   Increment lifts the counter to the floor, adds one (saturating) and
//   tracks the maximum; raise-all copies the maximum into the floor; read
//   returns max(counter, floor) with its index and an out-of-range flag.
//   Only reads produce a response on the rsp_valid / rsp_stall channel.
//   An in-range increment is one read-modify-write of the counter RAM and a
//   read one RAM read: a request is taken in idle, the RAM data returns in
//   the next cycle, and the write back or response load happens in execute.
//   No new request is taken before that; raise-all, unused codes and
//   out-of-range increments finish in idle with no execute step. While the
//   response register is full and stalled, a further read holds in execute
//   and the request channel stalls; the waiting response itself stays
//   intact. After reset the RAM is cleared one entry per cycle, all 1024
//   entries, with req_stall high; register writes are taken throughout.
// -----------------------------------------------------------------------------
`include "counter_bank_lazy_raise_to_max_unit_assert.svh"

module counter_bank_lazy_raise_to_max_unit (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [cbl_pkg::FUNC_W-1:0]         req_func,
   input  logic [cbl_pkg::INDEX_W-1:0]        req_counter_index,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [cbl_pkg::VALUE_W-1:0]        rsp_counter_value,
   output logic [cbl_pkg::INDEX_W-1:0]        rsp_read_index,
   output logic                               rsp_out_of_range,

   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [cbl_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [cbl_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [cbl_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);

   localparam int AW = cbl_pkg::ADDR_W;
   localparam int CW = cbl_pkg::COUNT_BITS;

   logic [cbl_pkg::ACTIVE_W-1:0] active_counters;

   cbl_pkg::cbl_state_type       state_ff, state_in;
   logic [AW-1:0]                clr_addr_ff, clr_addr_in;
   cbl_pkg::cbl_func_type        op_ff, op_in;
   logic [cbl_pkg::INDEX_W-1:0]  idx_ff, idx_in;
   logic                         in_range_ff, in_range_in;
   logic [CW-1:0]                running_max_ff, running_max_in;
   logic [CW-1:0]                lazy_floor_ff, lazy_floor_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [cbl_pkg::VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [cbl_pkg::INDEX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic                         rsp_oor_ff, rsp_oor_in;

   logic                         req_xfer;
   logic                         req_ok;
   logic                         rsp_free;

   logic                         ram_we;
   logic [AW-1:0]                ram_waddr;
   logic [CW-1:0]                ram_wdata;
   logic                         ram_re;
   logic [AW-1:0]                ram_raddr;
   logic [CW-1:0]                ram_rdata;

   logic [CW-1:0]                floored;
   logic [CW-1:0]                bumped;

   cbl_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .active_counters (active_counters)
   );

   cbl_ram #(
      .WIDTH (CW),
      .DEPTH (cbl_pkg::COUNTER_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_stall = (state_ff != cbl_pkg::ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign req_ok    = cbl_pkg::index_ok(req_counter_index, active_counters);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign floored = (ram_rdata < lazy_floor_ff) ? lazy_floor_ff : ram_rdata;
   assign bumped  = (floored == '1) ? floored : floored + CW'(1);

   assign ram_re    = req_xfer;
   assign ram_raddr = AW'(req_counter_index);

   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      op_in          = op_ff;
      idx_in         = idx_ff;
      in_range_in    = in_range_ff;
      running_max_in = running_max_ff;
      lazy_floor_in  = lazy_floor_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_oor_in     = rsp_oor_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      ram_we         = 1'b0;
      ram_waddr      = AW'(idx_ff);
      ram_wdata      = bumped;

      case (state_ff)
         cbl_pkg::ST_CLEAR: begin
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            ram_wdata   = '0;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(cbl_pkg::COUNTER_DEPTH - 1)) begin
               state_in = cbl_pkg::ST_IDLE;
            end
         end
         cbl_pkg::ST_IDLE: begin
            if (req_xfer) begin
               op_in       = cbl_pkg::cbl_func_type'(req_func);
               idx_in      = req_counter_index;
               in_range_in = req_ok;
               case (cbl_pkg::cbl_func_type'(req_func))
                  cbl_pkg::FUNC_INC: begin
                     if (req_ok) begin
                        state_in = cbl_pkg::ST_EXEC;
                     end
                  end
                  cbl_pkg::FUNC_RAISE: begin
                     lazy_floor_in = running_max_ff;
                  end
                  cbl_pkg::FUNC_READ: begin
                     state_in = cbl_pkg::ST_EXEC;
                  end
                  default: begin
                  end
               endcase
            end
         end
         cbl_pkg::ST_EXEC: begin
            case (op_ff)
               cbl_pkg::FUNC_INC: begin
                  ram_we   = 1'b1;
                  state_in = cbl_pkg::ST_IDLE;
                  if (bumped > running_max_ff) begin
                     running_max_in = bumped;
                  end
               end
               cbl_pkg::FUNC_READ: begin
                  if (rsp_free) begin
                     rsp_valid_in = 1'b1;
                     rsp_value_in = in_range_ff ? cbl_pkg::VALUE_W'(floored) : '0;
                     rsp_index_in = idx_ff;
                     rsp_oor_in   = !in_range_ff;
                     state_in     = cbl_pkg::ST_IDLE;
                  end
               end
               default: begin
                  state_in = cbl_pkg::ST_IDLE;
               end
            endcase
         end
         default: begin
            state_in = cbl_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= cbl_pkg::ST_CLEAR;
         clr_addr_ff    <= '0;
         running_max_ff <= '0;
         lazy_floor_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_addr_ff    <= clr_addr_in;
         running_max_ff <= running_max_in;
         lazy_floor_ff  <= lazy_floor_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      idx_ff       <= idx_in;
      in_range_ff  <= in_range_in;
      rsp_value_ff <= rsp_value_in;
      rsp_index_ff <= rsp_index_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_counter_value = rsp_value_ff;
   assign rsp_read_index    = rsp_index_ff;
   assign rsp_out_of_range  = rsp_oor_ff;

   `CBL_ASSERT_IMP(a_clear_blocks_req, clock, reset, state_ff == cbl_pkg::ST_CLEAR, req_stall)
   `CBL_ASSERT_IMP(a_floor_le_max, clock, reset, 1'b1, lazy_floor_ff <= running_max_ff)
   `CBL_ASSERT_IMP(a_write_in_range, clock, reset, ram_we && state_ff == cbl_pkg::ST_EXEC, in_range_ff)
   `CBL_ASSERT_NEXT(a_read_loads_rsp, clock, reset, state_ff == cbl_pkg::ST_EXEC && op_ff == cbl_pkg::FUNC_READ && rsp_free, rsp_valid && rsp_read_index == $past(idx_ff))

endmodule

@@ bench/counter_bank_lazy_raise_to_max_unit_tb.sv @@
// -----------------------------------------------------------------------------
// Counter bank lazy-floor testbench
// Drives increment, raise-all and read requests through the request channel.
// The active count is changed between phases over the register port and read
// back. A shadow copy of the counters, maximum and floor predicts every read
// response, and responses are checked field by field in order. The sender
// works in bursts and the receiver stalls, with one long hold-off.
// -----------------------------------------------------------------------------
module counter_bank_lazy_raise_to_max_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [cbl_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 8;

   typedef struct {
      logic [cbl_pkg::VALUE_W-1:0] value;
      logic [cbl_pkg::INDEX_W-1:0] index;
      logic                        oor;
   } read_result_type;

   class counter_bank_shadow_type;
      bit [cbl_pkg::COUNT_BITS-1:0] counts [cbl_pkg::COUNTER_DEPTH];
      bit [cbl_pkg::COUNT_BITS-1:0] peak;
      bit [cbl_pkg::COUNT_BITS-1:0] floor_level;
      bit [cbl_pkg::ACTIVE_W-1:0]   active;
      read_result_type              expected_reads [$];
      int                           mismatches;
      int                           requests_seen;
      int                           reads_checked;

      function new();
         foreach (counts[i]) counts[i] = '0;
         peak          = '0;
         floor_level   = '0;
         active        = cbl_pkg::ACTIVE_RESET;
         mismatches    = 0;
         requests_seen = 0;
         reads_checked = 0;
      endfunction

      function bit in_range(logic [cbl_pkg::INDEX_W-1:0] idx);
         return (32'(idx) < 32'(active)) && (32'(idx) < cbl_pkg::COUNTER_DEPTH);
      endfunction

      task report(string msg);
         mismatches++;
         $display("[%0t] MISMATCH: %s", $realtime, msg);
      endtask

      function void note_request(logic [cbl_pkg::FUNC_W-1:0] f,
                                 logic [cbl_pkg::INDEX_W-1:0] idx);
         bit [cbl_pkg::COUNT_BITS-1:0] v;
         read_result_type r;
         requests_seen++;
         case (f)
            cbl_pkg::FUNC_INC: begin
               if (in_range(idx)) begin
                  v = counts[idx];
                  if (v < floor_level)
                     v = floor_level;
                  if (v != {cbl_pkg::COUNT_BITS{1'b1}})
                     v = v + 1'b1;
                  counts[idx] = v;
                  if (peak < v)
                     peak = v;
               end
            end
            cbl_pkg::FUNC_RAISE: begin
               floor_level = peak;
            end
            cbl_pkg::FUNC_READ: begin
               r.index = idx;
               if (in_range(idx)) begin
                  v = counts[idx];
                  if (v < floor_level)
                     v = floor_level;
                  r.value = cbl_pkg::VALUE_W'(v);
                  r.oor   = 1'b0;
               end else begin
                  r.value = '0;
                  r.oor   = 1'b1;
               end
               expected_reads.push_back(r);
            end
            default: begin
            end
         endcase
      endfunction

      task check_read(logic [cbl_pkg::VALUE_W-1:0] value,
                      logic [cbl_pkg::INDEX_W-1:0] idx, logic oor);
         read_result_type r;
         if (expected_reads.size() == 0) begin
            report($sformatf("response with none pending: value %0h index %0d", value, idx));
         end else begin
            r = expected_reads.pop_front();
            reads_checked++;
            if (value !== r.value)
               report($sformatf("counter_value %0h, expected %0h (index %0d)",
                                value, r.value, r.index));
            if (idx !== r.index)
               report($sformatf("read_index %0d, expected %0d", idx, r.index));
            if (oor !== r.oor)
               report($sformatf("out_of_range %b, expected %b (index %0d)",
                                oor, r.oor, r.index));
         end
      endtask
   endclass

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic [cbl_pkg::FUNC_W-1:0]     req_func;
   logic [cbl_pkg::INDEX_W-1:0]    req_counter_index;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic [cbl_pkg::VALUE_W-1:0]    rsp_counter_value;
   logic [cbl_pkg::INDEX_W-1:0]    rsp_read_index;
   logic                           rsp_out_of_range;
   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [cbl_pkg::CSR_ADDR_W-1:0] paddr;
   logic [cbl_pkg::CSR_DATA_W-1:0] pwdata;
   logic [cbl_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;

   counter_bank_shadow_type sb = new();
   int  cycle_count = 0;
   int  settings_used = 0;
   bit  long_hold_req = 1'b0;

   counter_bank_lazy_raise_to_max_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_counter_index (req_counter_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_counter_value (rsp_counter_value),
      .rsp_read_index    (rsp_read_index),
      .rsp_out_of_range  (rsp_out_of_range),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses pending",
                  cycle_count, sb.expected_reads.size());
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (req_valid === 1'b1 && req_stall === 1'b0)
            sb.note_request(req_func, req_counter_index);
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
            sb.check_read(rsp_counter_value, rsp_read_index, rsp_out_of_range);
      end
   end

   // receiver: stall in segments of varying density, hold off on request
   initial begin
      int seg_len;
      int density;
      rsp_stall = 1'b0;
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            repeat (400) begin
               @(posedge clock);
               rsp_stall <= 1'b1;
            end
         end
         seg_len = $urandom_range(10, 60);
         case ($urandom_range(0, 3))
            0: density = 0;
            1: density = 30;
            2: density = 60;
            default: density = 90;
         endcase
         repeat (seg_len) begin
            @(posedge clock);
            rsp_stall <= ($urandom_range(1, 100) <= density);
         end
      end
   end

   task automatic send_request(input logic [cbl_pkg::FUNC_W-1:0] f,
                               input logic [cbl_pkg::INDEX_W-1:0] idx);
      req_valid         <= 1'b1;
      req_func          <= f;
      req_counter_index <= idx;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
   endtask

   task automatic wait_drained();
      while (sb.expected_reads.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_active(input logic [cbl_pkg::ACTIVE_W-1:0] value);
      logic [cbl_pkg::CSR_DATA_W-1:0] readback;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= cbl_pkg::CSR_ACTIVE_ADDR;
      pwdata  <= cbl_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      readback = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      sb.active = value;
      settings_used++;
      if (readback !== cbl_pkg::CSR_DATA_W'(value))
         sb.report($sformatf("active_counters reads %0h, expected %0h", readback, value));
   endtask

   task automatic run_random(input int count);
      int burst_left;
      int gap;
      int pick;
      int b;
      logic [cbl_pkg::FUNC_W-1:0]  f;
      logic [cbl_pkg::INDEX_W-1:0] idx;
      burst_left = 0;
      for (int k = 0; k < count; k++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
         pick = $urandom_range(0, 99);
         if (pick < 50)
            f = cbl_pkg::FUNC_INC;
         else if (pick < 85)
            f = cbl_pkg::FUNC_READ;
         else if (pick < 95)
            f = cbl_pkg::FUNC_RAISE;
         else
            f = FUNC_UNUSED;
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            idx = cbl_pkg::INDEX_W'($urandom_range(0, 7));
         end else if (pick < 8) begin
            idx = cbl_pkg::INDEX_W'($urandom_range(0, cbl_pkg::COUNTER_DEPTH - 1));
         end else begin
            b = int'(sb.active) + int'($urandom_range(0, 2)) - 1;
            if (b < 0) b = 0;
            if (b > cbl_pkg::COUNTER_DEPTH - 1) b = cbl_pkg::COUNTER_DEPTH - 1;
            idx = cbl_pkg::INDEX_W'(b);
         end
         send_request(f, idx);
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_func          = cbl_pkg::FUNC_INC;
      req_counter_index = '0;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset-value active count: zero reads, extremes, floor and maximum
      send_request(cbl_pkg::FUNC_READ, 10'd0);
      send_request(cbl_pkg::FUNC_READ, 10'd1023);
      send_request(cbl_pkg::FUNC_INC, 10'd0);
      send_request(cbl_pkg::FUNC_INC, 10'd0);
      send_request(cbl_pkg::FUNC_INC, 10'd1023);
      send_request(cbl_pkg::FUNC_READ, 10'd0);
      send_request(cbl_pkg::FUNC_READ, 10'd1023);
      send_request(FUNC_UNUSED, 10'd5);
      send_request(cbl_pkg::FUNC_READ, 10'd5);
      send_request(cbl_pkg::FUNC_RAISE, 10'd0);
      send_request(cbl_pkg::FUNC_READ, 10'd5);
      send_request(cbl_pkg::FUNC_READ, 10'd1);
      send_request(cbl_pkg::FUNC_INC, 10'd1);
      send_request(cbl_pkg::FUNC_INC, 10'd5);
      send_request(cbl_pkg::FUNC_READ, 10'd1);
      send_request(cbl_pkg::FUNC_RAISE, 10'd0);
      send_request(cbl_pkg::FUNC_READ, 10'd1023);
      send_request(cbl_pkg::FUNC_INC, 10'd0);
      send_request(cbl_pkg::FUNC_READ, 10'd0);
      send_request(cbl_pkg::FUNC_READ, 10'd682);
      send_request(cbl_pkg::FUNC_READ, 10'd341);
      send_request(cbl_pkg::FUNC_READ, 10'd512);
      req_valid <= 1'b0;
      run_random(60);

      wait_drained();
      write_active(11'd16);
      long_hold_req = 1'b1;
      run_random(70);

      wait_drained();
      write_active(11'd1);
      run_random(50);

      wait_drained();
      write_active(11'd0);
      run_random(40);

      wait_drained();
      write_active(11'd2047);
      run_random(60);

      wait_drained();
      write_active(cbl_pkg::ACTIVE_W'($urandom_range(2, 1023)));
      run_random(60);

      wait_drained();
      write_active(11'd1024);
      run_random(60);

      wait_drained();
      repeat (20) @(posedge clock);
      $display("Covered %0d requests and %0d checked reads over %0d active-count settings",
               sb.requests_seen, sb.reads_checked, settings_used + 1);
      $display("Largest counter reached %0d, final floor %0d", sb.peak, sb.floor_level);
      if (sb.mismatches == 0 && sb.expected_reads.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches, %0d responses missing",
                  sb.mismatches, sb.expected_reads.size());
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
